// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the top level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent true in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// expression never true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error(msg);

`endif

// ===== src/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// types, constants and register codes of the lc capacitance converter
// ----------------------------------------------------------------------------
package lcc_pkg;

    // defaults of the top level parameters
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int COUNT_BITS_DEF   = 28;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // field widths
    localparam int CH_W        = 2;
    localparam int WORD_W      = 16;
    localparam int RAW_COUNT_W = 28;
    localparam int FREQ_W      = 28;
    localparam int CAP_W       = 32;
    localparam int PAR_W       = 20;
    localparam int DIV_W       = 10;
    localparam int FIN_W       = 2;
    localparam int SCALE_W     = 28;
    localparam int SQ_W        = 2 * FREQ_W;
    localparam int DEN_W       = SQ_W + WORD_W;
    localparam int NUM_DIV_WORDS = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIV_CH0  = 3'd0,
        CFG_DIV_CH1  = 3'd1,
        CFG_DIV_CH2  = 3'd2,
        CFG_DIV_CH3  = 3'd3,
        CFG_REF_KHZ  = 3'd4,
        CFG_IND_NH   = 3'd5,
        CFG_PAR_FF   = 3'd6
    } t_cfg_idx;

    localparam logic [WORD_W-1:0] DIV_WORD_RST = 16'd4097;
    localparam logic [WORD_W-1:0] REF_KHZ_RST  = 16'd40000;
    localparam logic [WORD_W-1:0] IND_NH_RST   = 16'd18000;
    localparam logic [PAR_W-1:0]  PAR_FF_RST   = 20'd33000;

    localparam logic [SCALE_W-1:0] KHZ_TO_HZ = 28'd1000;
    localparam logic [FREQ_W-1:0]  FREQ_MAX  = 28'hFFF_FFFF;
    localparam logic [CAP_W-1:0]   CAP_MAX   = 32'h7FFF_FFFF;

    // 1e24 / (4 pi^2), femtofarad scaling of 1 / (L[nH] * f[Hz]^2)
    localparam int K_W    = 75;
    localparam int K_HI_W = K_W - CAP_W;
    localparam logic [K_W-1:0]    K_CAP  = 75'd25330295910584444000000;
    localparam logic [K_HI_W-1:0] K_HI   = K_CAP[K_W-1:CAP_W];
    localparam logic [CAP_W-1:0]  K_LO   = K_CAP[CAP_W-1:0];

    typedef struct packed {
        logic [NUM_DIV_WORDS-1:0][WORD_W-1:0] div_word;
        logic [WORD_W-1:0]                    ref_clock_khz;
        logic [WORD_W-1:0]                    inductance_nh;
        logic [PAR_W-1:0]                     parasitic_ff;
    } t_cfg_regs;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [WORD_W-1:0] raw_msb;
        logic [WORD_W-1:0] raw_lsb;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]         out_channel;
        logic signed [CAP_W-1:0] sensor_cap_ff;
        logic [FREQ_W-1:0]       freq_hz;
        logic                    watchdog_err;
        logic                    amplitude_warn;
        logic                    fresh;
        logic                    math_err;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_COMPUTE,
        KIND_FLAGGED,
        KIND_BAD_CH
    } t_kind;

    // classified request handed from front to back
    typedef struct packed {
        t_kind                  kind;
        logic [CH_W-1:0]        channel;
        logic                   wd;
        logic                   aw;
        logic [SCALE_W-1:0]     scale;
        logic [DIV_W-1:0]       div;
        logic [RAW_COUNT_W-1:0] count;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE,
        B_FMUL,
        B_FDIV,
        B_SQUARE,
        B_LMUL,
        B_CHECK,
        B_CDIV,
        B_FINISH,
        B_EMIT
    } t_back_state;

endpackage

// ===== src/lcc_stream_if.sv =====
// ----------------------------------------------------------------------------
// lcc_stream_if
// valid/ready stream channel carrying one payload item
// ----------------------------------------------------------------------------
interface lcc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/lcc_front.sv =====
// ----------------------------------------------------------------------------
// lcc_front
// accepts a raw conversion, unpacks flags and count, classifies the request
// and looks up the channel clock word
// ----------------------------------------------------------------------------
module lcc_front import lcc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    input  t_cfg_regs i_cfg,
    output logic      o_job_valid,
    output t_job      o_job,
    input  logic      i_job_ready
);

    localparam logic [RAW_COUNT_W-1:0] COUNT_MASK = (COUNT_BITS >= RAW_COUNT_W) ? '1 :
        RAW_COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);

    logic             r_job_valid;
    t_job             r_job;
    t_job             n_job;
    logic [WORD_W-1:0]  div_word;
    logic [SCALE_W-1:0] f_hz;
    logic               accept;

    assign o_in_ready  = !r_job_valid || i_job_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    always_comb begin
        div_word      = i_cfg.div_word[i_in_item.channel];
        f_hz          = SCALE_W'(i_cfg.ref_clock_khz) * KHZ_TO_HZ;
        n_job.channel = i_in_item.channel;
        n_job.wd      = i_in_item.raw_msb[13];
        n_job.aw      = i_in_item.raw_msb[12];
        n_job.count   = {i_in_item.raw_msb[11:0], i_in_item.raw_lsb} & COUNT_MASK;
        n_job.div     = div_word[DIV_W-1:0];
        // input multiplier of 0..3 applied as shift and add
        unique case (div_word[13:12])
            2'd0:    n_job.scale = '0;
            2'd1:    n_job.scale = f_hz;
            2'd2:    n_job.scale = {f_hz[SCALE_W-2:0], 1'b0};
            default: n_job.scale = f_hz + {f_hz[SCALE_W-2:0], 1'b0};
        endcase
        priority if (int'(i_in_item.channel) >= NUM_CHANNELS) begin
            n_job.kind = KIND_BAD_CH;
        end else if (n_job.wd || n_job.aw) begin
            n_job.kind = KIND_FLAGGED;
        end else begin
            n_job.kind = KIND_COMPUTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (accept) begin
            r_job_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== src/lcc_queue.sv =====
// ----------------------------------------------------------------------------
// lcc_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module lcc_queue import lcc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== src/lcc_back.sv =====
// ----------------------------------------------------------------------------
// lcc_back
// sequencer for frequency and capacitance: multiply, shift-subtract divide,
// square, scale by inductance, divide the constant, subtract parasitic
// ----------------------------------------------------------------------------
module lcc_back import lcc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_regs i_cfg,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_out_item o_res
);

    localparam int CNT_W  = (COUNT_BITS < RAW_COUNT_W) ? COUNT_BITS : RAW_COUNT_W;
    localparam int PROD_W = SCALE_W + CNT_W;
    localparam int STEP_W = $clog2(CAP_W);

    t_back_state r_state;
    t_back_state n_state;

    t_job               r_job;
    logic               r_err;
    logic               r_fresh;
    logic [FREQ_W-1:0]  r_freq;
    logic [CNT_W-1:0]   r_fq;
    logic [DIV_W-1:0]   r_rem_f;
    logic [SQ_W-1:0]    r_sq;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem_c;
    logic [CAP_W-1:0]   r_cq;
    logic [STEP_W-1:0]  r_step;
    logic [CAP_W-1:0]   r_cap;
    logic [CAP_W-1:0]   r_last [NUM_CHANNELS];
    logic               r_out_valid;
    t_out_item          r_out;

    logic [PROD_W-1:0]  prod;
    logic [DIV_W:0]     f_sh;
    logic               f_ge;
    logic [DIV_W:0]     f_diff;
    logic [DEN_W:0]     c_sh;
    logic               c_ge;
    logic [DEN_W:0]     c_diff;
    logic               early_sat;
    logic signed [CAP_W+1:0] fin_diff;
    logic               fin_sat;
    logic [CAP_W-1:0]   last_sel;
    logic               emit;

    // datapath helpers
    always_comb begin
        prod      = PROD_W'(r_job.scale) * PROD_W'(r_job.count[CNT_W-1:0]);
        f_sh      = {r_rem_f, r_fq[CNT_W-1]};
        f_diff    = f_sh - {1'b0, r_job.div};
        f_ge      = (f_sh >= {1'b0, r_job.div});
        c_sh      = {r_rem_c, r_cq[CAP_W-1]};
        c_diff    = c_sh - {1'b0, r_den};
        c_ge      = (c_sh >= {1'b0, r_den});
        // quotient of at least 2^32 always exceeds the signed range after subtract
        early_sat = (r_den == '0) || (DEN_W'(K_HI) >= r_den);
        fin_diff  = $signed({2'b00, r_cq})
                  - $signed({{(CAP_W + 2 - PAR_W){1'b0}}, i_cfg.parasitic_ff});
        fin_sat   = !fin_diff[CAP_W+1] && (fin_diff[CAP_W:CAP_W-1] != 2'b00);
        last_sel  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (int'(i_job.channel) == i) begin
                last_sel = r_last[i];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.kind == KIND_COMPUTE) ? B_FMUL : B_EMIT;
                end
            end
            B_FMUL:   n_state = (r_job.div == '0) ? B_SQUARE : B_FDIV;
            B_FDIV:   n_state = (r_step == '0) ? B_SQUARE : B_FDIV;
            B_SQUARE: n_state = B_LMUL;
            B_LMUL:   n_state = B_CHECK;
            B_CHECK:  n_state = early_sat ? B_EMIT : B_CDIV;
            B_CDIV:   n_state = (r_step == '0) ? B_FINISH : B_CDIV;
            B_FINISH: n_state = B_EMIT;
            B_EMIT: begin
                if (emit) begin
                    n_state = B_IDLE;
                end
            end
            default:  n_state = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_job_ready = (r_state == B_IDLE);
        emit        = (r_state == B_EMIT) && (!r_out_valid || i_res_ready);
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_last[i] <= '0;
            end
        end else if (emit && r_fresh) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (int'(r_job.channel) == i) begin
                    r_last[i] <= r_cap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    r_job   <= i_job;
                    r_err   <= (i_job.kind == KIND_BAD_CH);
                    r_fresh <= (i_job.kind == KIND_COMPUTE);
                    r_freq  <= '0;
                    r_cap   <= (i_job.kind == KIND_FLAGGED) ? last_sel : '0;
                end
            end
            B_FMUL: begin
                r_fq    <= prod[PROD_W-1 -: CNT_W];
                r_rem_f <= '0;
                r_step  <= STEP_W'(CNT_W - 1);
                // zero divider counts as infinite frequency
                if (r_job.div == '0) begin
                    r_freq <= FREQ_MAX;
                    r_err  <= 1'b1;
                end
            end
            B_FDIV: begin
                // quotient stays below 2^28 since the scaled count does
                r_rem_f <= f_ge ? f_diff[DIV_W-1:0] : f_sh[DIV_W-1:0];
                r_fq    <= {r_fq[CNT_W-2:0], f_ge};
                r_step  <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_freq <= FREQ_W'({r_fq[CNT_W-2:0], f_ge});
                end
            end
            B_SQUARE: begin
                r_sq <= SQ_W'(r_freq) * SQ_W'(r_freq);
            end
            B_LMUL: begin
                r_den <= DEN_W'(r_sq) * DEN_W'(i_cfg.inductance_nh);
            end
            B_CHECK: begin
                r_rem_c <= DEN_W'(K_HI);
                r_cq    <= K_LO;
                r_step  <= STEP_W'(CAP_W - 1);
                if (early_sat) begin
                    r_cap <= CAP_MAX;
                    r_err <= 1'b1;
                end
            end
            B_CDIV: begin
                r_rem_c <= c_ge ? c_diff[DEN_W-1:0] : c_sh[DEN_W-1:0];
                r_cq    <= {r_cq[CAP_W-2:0], c_ge};
                r_step  <= r_step - 1'b1;
            end
            B_FINISH: begin
                if (fin_sat) begin
                    r_cap <= CAP_MAX;
                    r_err <= 1'b1;
                end else begin
                    r_cap <= fin_diff[CAP_W-1:0];
                end
            end
            B_EMIT: begin
                if (emit) begin
                    r_out.out_channel    <= r_job.channel;
                    r_out.sensor_cap_ff  <= r_cap;
                    r_out.freq_hz        <= r_freq;
                    r_out.watchdog_err   <= r_job.wd;
                    r_out.amplitude_warn <= r_job.aw;
                    r_out.fresh          <= r_fresh;
                    r_out.math_err       <= r_err;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/lc_resonance_capacitance_converter_top.sv =====
// ----------------------------------------------------------------------------
// lc_resonance_capacitance_converter_top
// lc tank frequency to capacitance converter with per channel hold of the
// last good value
// ----------------------------------------------------------------------------
// path: a computed request passes the front register, the queue and the back
//   sequencer; a flagged or bad-channel one goes straight from idle to emit
// pacing: the back sequencer takes a new request only after emitting the last one,
//   and its two shift-subtract dividers produce one bit per cycle
// reset: synchronous active low; registers take their defaults, last good values clear
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lc_resonance_capacitance_converter_top import lcc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lcc_stream_if.sink            i_in,
    lcc_stream_if.source          o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg_regs r_cfg;

    logic      front_valid;
    logic      front_ready;
    t_job      front_job;
    logic      back_valid;
    logic      back_ready;
    t_job      back_job;
    logic      res_valid;
    t_out_item res_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIV_WORDS; i++) begin
                r_cfg.div_word[i] <= DIV_WORD_RST;
            end
            r_cfg.ref_clock_khz <= REF_KHZ_RST;
            r_cfg.inductance_nh <= IND_NH_RST;
            r_cfg.parasitic_ff  <= PAR_FF_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DIV_CH0: r_cfg.div_word[0]  <= i_cfg_wdata[WORD_W-1:0];
                CFG_DIV_CH1: r_cfg.div_word[1]  <= i_cfg_wdata[WORD_W-1:0];
                CFG_DIV_CH2: r_cfg.div_word[2]  <= i_cfg_wdata[WORD_W-1:0];
                CFG_DIV_CH3: r_cfg.div_word[3]  <= i_cfg_wdata[WORD_W-1:0];
                CFG_REF_KHZ: r_cfg.ref_clock_khz <= i_cfg_wdata[WORD_W-1:0];
                CFG_IND_NH:  r_cfg.inductance_nh <= i_cfg_wdata[WORD_W-1:0];
                CFG_PAR_FF:  r_cfg.parasitic_ff  <= i_cfg_wdata[PAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lcc_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_item   (i_in.data),
        .i_cfg       (r_cfg),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (front_ready)
    );

    lcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_job)
    );

    lcc_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .i_job       (back_job),
        .o_res_valid (res_valid),
        .i_res_ready (o_out.ready),
        .o_res       (res_item)
    );

    assign o_out.valid = res_valid;
    assign o_out.data  = res_item;

    // a fresh zero frequency always means a zero denominator
    `ASSERT_IMPLY(a_zero_freq_err, i_clk, i_rst_n,
        o_out.valid && o_out.data.fresh && (o_out.data.freq_hz == '0),
        o_out.data.math_err && (o_out.data.sensor_cap_ff == CAP_MAX),
        "fresh result with zero frequency lacks saturation")

    `ASSERT_IMPLY(a_held_no_freq, i_clk, i_rst_n,
        o_out.valid && !o_out.data.fresh,
        o_out.data.freq_hz == '0,
        "held result carries a frequency")

    `ASSERT_NEVER(a_flag_fresh, i_clk, i_rst_n,
        o_out.valid && o_out.data.fresh
            && (o_out.data.watchdog_err || o_out.data.amplitude_warn),
        "flagged conversion reported as freshly computed")

    `ASSERT_IMPLY(a_bad_channel, i_clk, i_rst_n,
        o_out.valid && (int'(o_out.data.out_channel) >= NUM_CHANNELS),
        !o_out.data.fresh && o_out.data.math_err && (o_out.data.sensor_cap_ff == '0),
        "out of range channel not rejected")

endmodule

// ===== bench/lc_resonance_capacitance_converter_top_test.sv =====
// ----------------------------------------------------------------------------
// lc_resonance_capacitance_converter_top_test
// drives raw conversions through the converter under several register settings
// and traffic patterns, predicts frequency, capacitance, flags and held values
// per channel, and compares every result field in order
// ----------------------------------------------------------------------------
module lc_resonance_capacitance_converter_top_test import lcc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int NUM_CFG         = 7;
    localparam int NUM_PHASES      = 12;
    localparam int REQS_PER_PHASE  = 94;
    localparam int SETTLE_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PRINT_LIMIT     = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic [FREQ_W-1:0]    FREQ_SAT      = 28'hFFF_FFFF;
    localparam logic [CAP_W-1:0]     CAP_SAT       = 32'h7FFF_FFFF;
    // 1e24 / (4 pi^2): femtofarads from nanohenries and hertz
    localparam logic [127:0]         CAP_SCALE     = 128'd25330295910584444000000;

    localparam t_in_item DIRECTED_REQS [14] = '{
        '{2'd0, 16'h0000, 16'h0000},
        '{2'd0, 16'h0FFF, 16'hFFFF},
        '{2'd1, 16'h0200, 16'h0000},
        '{2'd1, 16'h2200, 16'h0000},
        '{2'd1, 16'h1200, 16'h0000},
        '{2'd2, 16'h3FFF, 16'hFFFF},
        '{2'd3, 16'h0000, 16'h0001},
        '{2'd3, 16'h0000, 16'h0007},
        '{2'd2, 16'hC123, 16'h4567},
        '{2'd0, 16'hFFFF, 16'hFFFF},
        '{2'd3, 16'h0040, 16'hAAAA},
        '{2'd2, 16'hD555, 16'h5555},
        '{2'd1, 16'hE000, 16'h0000},
        '{2'd0, 16'h0000, 16'h0100}
    };

    class cap_scoreboard;
        logic [WORD_W-1:0]       div_word [NUM_DIV_WORDS];
        logic [WORD_W-1:0]       ref_khz;
        logic [WORD_W-1:0]       ind_nh;
        logic [PAR_W-1:0]        par_ff;
        logic signed [CAP_W-1:0] held_cap [4];
        t_out_item               expected_caps [$];
        int                      mismatch_count;

        function new();
            foreach (div_word[i]) div_word[i] = DIV_WORD_RST;
            foreach (held_cap[i]) held_cap[i] = '0;
            ref_khz = REF_KHZ_RST;
            ind_nh = IND_NH_RST;
            par_ff = PAR_FF_RST;
            mismatch_count = 0;
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DIV_CH0, CFG_DIV_CH1, CFG_DIV_CH2, CFG_DIV_CH3: begin
                    div_word[idx[1:0]] = data[WORD_W-1:0];
                end
                CFG_REF_KHZ: ref_khz = data[WORD_W-1:0];
                CFG_IND_NH:  ind_nh = data[WORD_W-1:0];
                CFG_PAR_FF:  par_ff = data[PAR_W-1:0];
                default: ;
            endcase
        endfunction

        function t_out_item predict_capacitance(t_in_item req);
            t_out_item         res;
            logic [27:0]       count;
            logic [WORD_W-1:0] word;
            logic [63:0]       numer;
            logic [63:0]       quot;
            logic [127:0]      den;
            logic [127:0]      total;
            logic signed [63:0] diff;
            res = '0;
            count = {req.raw_msb[11:0], req.raw_lsb};
            res.out_channel = req.channel;
            res.watchdog_err = req.raw_msb[13];
            res.amplitude_warn = req.raw_msb[12];
            // flagged conversion repeats the channel's last good value
            if (req.raw_msb[13] || req.raw_msb[12]) begin
                res.sensor_cap_ff = held_cap[req.channel];
                return res;
            end
            res.fresh = 1'b1;
            word = div_word[req.channel];
            numer = 64'(word[13:12]) * 64'(ref_khz) * 64'd1000 * 64'(count);
            if (word[9:0] == '0) begin
                res.freq_hz = FREQ_SAT;
                res.math_err = 1'b1;
            end else begin
                quot = numer / (64'(word[9:0]) << 28);
                if (quot > 64'(FREQ_SAT)) begin
                    res.freq_hz = FREQ_SAT;
                    res.math_err = 1'b1;
                end else begin
                    res.freq_hz = quot[FREQ_W-1:0];
                end
            end
            den = 128'(res.freq_hz) * 128'(res.freq_hz) * 128'(ind_nh);
            if (den == '0) begin
                res.sensor_cap_ff = CAP_SAT;
                res.math_err = 1'b1;
            end else begin
                total = CAP_SCALE / den;
                if (total > 128'(CAP_SAT) + 128'(par_ff)) begin
                    res.sensor_cap_ff = CAP_SAT;
                    res.math_err = 1'b1;
                end else begin
                    diff = $signed(total[63:0]) - $signed(64'(par_ff));
                    res.sensor_cap_ff = diff[CAP_W-1:0];
                end
            end
            held_cap[req.channel] = res.sensor_cap_ff;
            return res;
        endfunction

        function void note_request(t_in_item req);
            expected_caps.push_back(predict_capacitance(req));
        endfunction

        task report(string field, longint got, longint want);
            if (mismatch_count < PRINT_LIMIT) begin
                $display("%0t ns: %s got %0d expected %0d", $time, field, got, want);
            end
            mismatch_count++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_caps.size() == 0) begin
                report("unexpected result, cap", got.sensor_cap_ff, 0);
                return;
            end
            want = expected_caps.pop_front();
            if (got.out_channel !== want.out_channel)
                report("out_channel", got.out_channel, want.out_channel);
            if (got.sensor_cap_ff !== want.sensor_cap_ff)
                report("sensor_cap_ff", got.sensor_cap_ff, want.sensor_cap_ff);
            if (got.freq_hz !== want.freq_hz)
                report("freq_hz", got.freq_hz, want.freq_hz);
            if (got.watchdog_err !== want.watchdog_err)
                report("watchdog_err", got.watchdog_err, want.watchdog_err);
            if (got.amplitude_warn !== want.amplitude_warn)
                report("amplitude_warn", got.amplitude_warn, want.amplitude_warn);
            if (got.fresh !== want.fresh)
                report("fresh", got.fresh, want.fresh);
            if (got.math_err !== want.math_err)
                report("math_err", got.math_err, want.math_err);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    quiet_cycles = 0;
    cap_scoreboard         sb = new();

    lcc_stream_if #(.T(t_in_item))  in_if ();
    lcc_stream_if #(.T(t_out_item)) out_if ();

    lc_resonance_capacitance_converter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
            if (in_if.valid && in_if.ready) sb.note_request(in_if.data);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_in_item random_request();
        t_in_item    req;
        logic [27:0] count;
        case ($urandom_range(0, 9))
            0: count = 28'($urandom_range(0, 15));
            1: count = 28'hFFF_FFFF - 28'($urandom_range(0, 15));
            default: count = 28'($urandom());
        endcase
        req.channel = 2'($urandom_range(0, 3));
        req.raw_msb = {2'($urandom_range(0, 3)),
                       ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : 2'b00,
                       count[27:16]};
        req.raw_lsb = count[15:0];
        return req;
    endfunction

    task automatic set_traffic(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 63; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 63; end
            default: begin idle_pct = 24; stall_pct = 24; end
        endcase
    endtask

    // valid is left high after acceptance so back-to-back requests never toggle it
    task automatic send_request(input t_in_item req);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= req;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic drain(input int extra);
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_caps.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        sb.apply_config(idx, data);
    endtask

    task automatic load_setting(input int phase);
        logic [CFG_DATA_W-1:0] vals [NUM_CFG];
        t_cfg_idx              ci;
        case (phase)
            0: begin
                vals = '{20'h03000, 20'h00001, 20'h033FF, 20'h0FFFF,
                         20'd65535, 20'd65535, 20'd1000000};
            end
            1: begin
                vals = '{20'h01001, 20'h03001, 20'h02200, 20'h0CC00,
                         20'd1, 20'd0, 20'd0};
            end
            2: begin
                vals = '{20'(DIV_WORD_RST), 20'(DIV_WORD_RST), 20'(DIV_WORD_RST),
                         20'(DIV_WORD_RST), 20'(REF_KHZ_RST), 20'(IND_NH_RST),
                         20'(PAR_FF_RST)};
            end
            default: begin
                for (int i = 0; i < NUM_DIV_WORDS; i++) begin
                    vals[i] = 20'($urandom_range(0, 65535));
                    if ($urandom_range(0, 7) == 0) vals[i][9:0] = '0;
                end
                vals[CFG_REF_KHZ] = ($urandom_range(0, 7) == 0) ? 20'd1
                                  : 20'($urandom_range(1, 65535));
                vals[CFG_IND_NH] = ($urandom_range(0, 7) == 0) ? 20'd1
                                 : 20'($urandom_range(1, 65535));
                vals[CFG_PAR_FF] = 20'($urandom_range(0, 1000000));
            end
        endcase
        // junk above the 16-bit registers must be dropped
        for (int i = 0; i < NUM_CFG - 1; i++) vals[i][19:16] = 4'($urandom_range(0, 15));
        ci = ci.first();
        repeat (ci.num()) begin
            write_reg(ci, vals[ci]);
            ci = ci.next();
        end
        write_reg(CFG_IDX_SPARE, 20'($urandom()));
        cfg_we <= 1'b0;
    endtask

    initial begin
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_DIV_CH0;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_traffic(0);
        foreach (DIRECTED_REQS[i]) send_request(DIRECTED_REQS[i]);
        drain(SETTLE_CYCLES);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            load_setting(phase);
            set_traffic(phase % 4);
            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                // hold off new requests until the pipeline is empty
                if (phase % 3 == 1 && n == REQS_PER_PHASE / 2) drain(0);
                send_request(random_request());
            end
            drain(SETTLE_CYCLES);
        end

        if (sb.mismatch_count == 0 && sb.expected_caps.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
